### design/wmf_pkg.sv
// wmf_pkg: shared constants, register codes and pipeline control types
// for the window median filter. No dependencies.
package wmf_pkg;

    localparam int MAX_COLS_DEF = 1024;
    localparam int MAX_HALF_DEF = 2;
    localparam int MAX_ROWS     = 1024;
    localparam int ROW_W        = 10;   // row index
    localparam int ROWS_W       = 11;   // row count
    localparam int PIX_W        = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 11;
    localparam int ROWS_RST     = 512;
    localparam int COLS_RST     = 512;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_HALF = 2'd0,
        REG_IMAGE_COLS  = 2'd1,
        REG_IMAGE_ROWS  = 2'd2
    } cfg_reg_t;

    // control that travels alongside window data through the median stages
    typedef struct packed {
        logic valid;
        logic last;
    } stage_ctl_t;

endpackage

### design/wmf_if.sv
// wmf_if: valid/ready stream interfaces for pixel input and median output.
// Depends on wmf_pkg.
interface wmf_in_if;
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic [wmf_pkg::PIX_W-1:0]  pixel;

    modport source (output valid, output func, output pixel, input ready);
    modport sink   (input valid, input func, input pixel, output ready);
endinterface

interface wmf_out_if;
    logic                       valid;
    logic                       ready;
    logic [wmf_pkg::PIX_W-1:0]  median;
    logic                       frame_end;

    modport source (output valid, output median, output frame_end, input ready);
    modport sink   (input valid, input median, input frame_end, output ready);
endinterface

### design/wmf_ram.sv
// wmf_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module wmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

### design/wmf_col_cell.sv
// wmf_col_cell: one column of the sliding window; takes its neighbor's
// column on each shift. Depends on wmf_pkg.
module wmf_col_cell #(
    parameter int W = 5
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [wmf_pkg::PIX_W-1:0] col_in  [W],
    output logic [wmf_pkg::PIX_W-1:0] col_out [W]
);
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col_out <= col_in;
        end
    end
endmodule

### design/wmf_bit_cell.sv
// wmf_bit_cell: one bit of the MSB-first rank select. Counts live
// candidates with a zero at BIT and decides that result bit.
// Depends on wmf_pkg.
module wmf_bit_cell #(
    parameter int N   = 25,
    parameter int KW  = 5,
    parameter int BIT = 7
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  wmf_pkg::stage_ctl_t        ctl_in,
    input  logic [wmf_pkg::PIX_W-1:0]  vals_in [N],
    input  logic [N-1:0]               alive_in,
    input  logic [KW-1:0]              k_in,
    input  logic [wmf_pkg::PIX_W-1:0]  res_in,
    output wmf_pkg::stage_ctl_t        ctl_out,
    output logic [wmf_pkg::PIX_W-1:0]  vals_out [N],
    output logic [N-1:0]               alive_out,
    output logic [KW-1:0]              k_out,
    output logic [wmf_pkg::PIX_W-1:0]  res_out
);
    import wmf_pkg::*;

    logic [N-1:0]      alive_next;
    logic [KW-1:0]     k_next;
    logic              bit_one;

    // zero count among live candidates decides the bit
    always_comb
    begin
        int zeros;
        zeros = 0;
        for (int i = 0; i < N; i++)
        begin
            if (alive_in[i] && !vals_in[i][BIT])
            begin
                zeros = zeros + 1;
            end
        end
        bit_one = (int'(k_in) >= zeros);
        k_next  = bit_one ? KW'(int'(k_in) - zeros) : k_in;
        for (int i = 0; i < N; i++)
        begin
            alive_next[i] = alive_in[i] && (vals_in[i][BIT] == bit_one);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_out <= '0;
        end
        else if (en)
        begin
            ctl_out <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vals_out  <= vals_in;
            alive_out <= alive_next;
            k_out     <= k_next;
            res_out   <= res_in | (PIX_W'(bit_one) << BIT);
        end
    end
endmodule

### design/window_median_filter.sv
// window_median_filter: top level; line stores, window column chain and
// bitwise rank-select pipeline. Depends on wmf_pkg, wmf_if, wmf_ram,
// wmf_col_cell, wmf_bit_cell.
//
// Streaming 3x3 / 5x5 median over 8-bit grey frames with replicated
// borders. The input side takes one transaction per clock while the
// filter keeps up; outputs come in raster order, one per credited item.
// The filter reads one window column per clock from the line stores
// while it holds credit and the output is not stalled, issuing
// cols + 2*h reads per output line (the 2*h extra reads load the
// replicated left and right edge columns); its rate is set by the single
// column read of the line stores. Input is held off while it runs more
// than 2*MAX_HALF+1-h lines ahead of the line being filtered. The last
// needed column passes the read data register, the window column chain
// and the rank-select bit stages to the output register. No clearing pass.
module window_median_filter #(
    parameter int MAX_COLS = wmf_pkg::MAX_COLS_DEF,
    parameter int MAX_HALF = wmf_pkg::MAX_HALF_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    wmf_in_if.sink                         in_ch,
    wmf_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [wmf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wmf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import wmf_pkg::*;

    localparam int W   = 2 * MAX_HALF + 1;
    localparam int N   = W * W;
    localparam int NL  = 2 * MAX_HALF + 2;
    localparam int CIW = $clog2(MAX_COLS);
    localparam int CNW = $clog2(MAX_COLS + 1);
    localparam int HW  = $clog2(MAX_HALF + 1);
    localparam int SW  = $clog2(MAX_COLS + 2 * MAX_HALF);
    localparam int KW  = $clog2(N);
    localparam int LW  = $clog2(NL + 1) + 1;
    localparam int SLW = $clog2(NL);
    localparam int CRED_MAX = (NL + 1) * MAX_COLS;
    localparam int CRW = $clog2(CRED_MAX + 1);
    localparam int COLS_RST_EFF = (COLS_RST > MAX_COLS) ? MAX_COLS : COLS_RST;

    // effective geometry
    logic [HW-1:0]     half_reg;
    logic [CNW-1:0]    cols_reg;
    logic [ROWS_W-1:0] rows_reg;
    logic              cfg_hit;
    logic [CIW-1:0]    cols_m1;
    logic [ROW_W-1:0]  rows_m1;

    // input-side frame tracking
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [CIW-1:0]    in_col_reg, in_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [CIW-1:0]    out_col_reg, out_col_next;
    logic              in_done_reg, in_done_next;
    logic [SLW-1:0]    in_slot_reg, in_slot_next;
    logic [LW-1:0]     in_lines_reg, in_lines_next;
    logic              in_acc, pix_wr, grant;

    // filter engine
    logic [ROW_W-1:0]  eng_row_reg, eng_row_next;
    logic [SW-1:0]     eng_step_reg, eng_step_next;
    logic [SLW-1:0]    eng_slot_reg, eng_slot_next;
    logic [LW-1:0]     eng_lines_reg, eng_lines_next;
    logic [CRW-1:0]    credits_reg, credits_next;
    logic              adv, issue, step_emit, step_end, step_last;
    logic [CIW-1:0]    fetch_col;
    logic [SLW-1:0]    sel [W];
    logic [LW-1:0]     lead;

    logic              d_valid_reg, d_emit_reg, d_last_reg;
    logic [SLW-1:0]    d_sel_reg [W];
    logic [PIX_W-1:0]  rdata [NL];
    logic [PIX_W-1:0]  feed_col [W];
    logic [PIX_W-1:0]  win_col [W+1][W];
    logic              w_valid_reg, w_last_reg;

    // rank-select stages
    stage_ctl_t        st_ctl   [9];
    logic [PIX_W-1:0]  st_vals  [9][N];
    logic [N-1:0]      st_alive [9];
    logic [KW-1:0]     st_k     [9];
    logic [PIX_W-1:0]  st_res   [9];

    assign cols_m1 = CIW'(cols_reg - 1'b1);
    assign rows_m1 = ROW_W'(rows_reg - 1'b1);
    assign cfg_hit = cfg_we && (cfg_index == REG_WINDOW_HALF ||
                     cfg_index == REG_IMAGE_COLS || cfg_index == REG_IMAGE_ROWS);

    // configuration registers, stored already saturated
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= HW'(1);
            cols_reg <= CNW'(COLS_RST_EFF);
            rows_reg <= ROWS_W'(ROWS_RST);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW_HALF:
                begin
                    if (cfg_data[1:0] == 2'd0)
                        half_reg <= HW'(1);
                    else if (int'(cfg_data[1:0]) > MAX_HALF)
                        half_reg <= HW'(MAX_HALF);
                    else
                        half_reg <= HW'(cfg_data[1:0]);
                end
                REG_IMAGE_COLS:
                begin
                    if (cfg_data == '0)
                        cols_reg <= CNW'(1);
                    else if (int'(cfg_data) > MAX_COLS)
                        cols_reg <= CNW'(MAX_COLS);
                    else
                        cols_reg <= CNW'(cfg_data);
                end
                REG_IMAGE_ROWS:
                begin
                    if (cfg_data == '0)
                        rows_reg <= ROWS_W'(1);
                    else if (int'(cfg_data) > MAX_ROWS)
                        rows_reg <= ROWS_W'(MAX_ROWS);
                    else
                        rows_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // input accept: hold off when too far ahead of the filtered line
    assign lead        = in_lines_reg - eng_lines_reg;
    assign in_ch.ready = int'(lead) <= (2 * MAX_HALF + 1 - int'(half_reg));
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign pix_wr      = in_acc && !in_ch.func && !in_done_reg;

    // frame positions, window-complete test and credit grant
    always_comb
    begin
        logic [ROWS_W-1:0] need_r;
        logic [CNW:0]      need_c;
        logic              rdy;
        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        in_done_next  = in_done_reg;
        in_slot_next  = in_slot_reg;
        in_lines_next = in_lines_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        if (pix_wr)
        begin
            if (in_col_reg == cols_m1)
            begin
                in_col_next   = '0;
                in_slot_next  = (int'(in_slot_reg) == NL - 1) ? '0 : in_slot_reg + 1'b1;
                in_lines_next = in_lines_reg + 1'b1;
                if (in_row_reg == rows_m1)
                begin
                    in_row_next  = '0;
                    in_done_next = 1'b1;
                end
                else
                begin
                    in_row_next = in_row_reg + 1'b1;
                end
            end
            else
            begin
                in_col_next = in_col_reg + 1'b1;
            end
        end
        need_r = {1'b0, out_row_reg} + ROWS_W'(half_reg);
        if (need_r > {1'b0, rows_m1})
            need_r = {1'b0, rows_m1};
        need_c = (CNW+1)'(out_col_reg) + (CNW+1)'(half_reg);
        if (need_c > (CNW+1)'(cols_m1))
            need_c = (CNW+1)'(cols_m1);
        rdy = in_done_next || ({1'b0, in_row_next} > need_r) ||
              ({1'b0, in_row_next} == need_r && (CNW+1)'(in_col_next) > need_c);
        grant = in_acc && rdy;
        if (grant)
        begin
            if (out_col_reg == cols_m1)
            begin
                out_col_next = '0;
                if (out_row_reg == rows_m1)
                begin
                    out_row_next = '0;
                    in_done_next = 1'b0;
                end
                else
                begin
                    out_row_next = out_row_reg + 1'b1;
                end
            end
            else
            begin
                out_col_next = out_col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            in_done_reg  <= 1'b0;
            in_slot_reg  <= '0;
            in_lines_reg <= '0;
        end
        else if (cfg_hit)
        begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            in_done_reg  <= 1'b0;
            in_slot_reg  <= '0;
            in_lines_reg <= '0;
        end
        else
        begin
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            in_done_reg  <= in_done_next;
            in_slot_reg  <= in_slot_next;
            in_lines_reg <= in_lines_next;
        end
    end

    // line stores, one per line slot
    for (genvar g = 0; g < NL; g++)
    begin : g_line
        wmf_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_COLS)
        ) u_line (
            .clk   (clk),
            .we    (pix_wr && int'(in_slot_reg) == g),
            .waddr (in_col_reg),
            .wdata (in_ch.pixel),
            .re    (adv),
            .raddr (fetch_col),
            .rdata (rdata[g])
        );
    end

    // whole pipeline advances unless the output register is stalled
    assign adv = !out_ch.valid || out_ch.ready;

    // column fetch sequencing along the output line
    always_comb
    begin
        logic [SW-1:0] t;
        step_emit = eng_step_reg >= SW'(2 * int'(half_reg));
        step_end  = eng_step_reg == SW'(int'(cols_m1) + 2 * int'(half_reg));
        step_last = step_end && (eng_row_reg == rows_m1);
        t = eng_step_reg - SW'(half_reg);
        if (eng_step_reg < SW'(half_reg))
            fetch_col = '0;
        else if (t > SW'(cols_m1))
            fetch_col = cols_m1;
        else
            fetch_col = CIW'(t);
        issue = adv && (credits_reg != '0);

        eng_row_next   = eng_row_reg;
        eng_step_next  = eng_step_reg;
        eng_slot_next  = eng_slot_reg;
        eng_lines_next = eng_lines_reg;
        if (issue)
        begin
            if (step_end)
            begin
                eng_step_next  = '0;
                eng_row_next   = (eng_row_reg == rows_m1) ? '0 : eng_row_reg + 1'b1;
                eng_slot_next  = (int'(eng_slot_reg) == NL - 1) ? '0 : eng_slot_reg + 1'b1;
                eng_lines_next = eng_lines_reg + 1'b1;
            end
            else
            begin
                eng_step_next = eng_step_reg + 1'b1;
            end
        end
        credits_next = credits_reg + CRW'(grant) - CRW'(issue && step_emit);
    end

    // line slot for each window row, rows clamped to the frame
    always_comb
    begin
        int r;
        int d;
        int s;
        for (int i = 0; i < W; i++)
        begin
            r = int'(eng_row_reg) + i - MAX_HALF;
            if (r < 0)
                r = 0;
            if (r > int'(rows_m1))
                r = int'(rows_m1);
            d = r - int'(eng_row_reg);
            s = int'(eng_slot_reg) + d;
            if (s < 0)
                s = s + NL;
            else if (s >= NL)
                s = s - NL;
            sel[i] = SLW'(s);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eng_row_reg   <= '0;
            eng_step_reg  <= '0;
            eng_slot_reg  <= '0;
            eng_lines_reg <= '0;
            credits_reg   <= '0;
            d_valid_reg   <= 1'b0;
            w_valid_reg   <= 1'b0;
        end
        else if (cfg_hit)
        begin
            eng_row_reg   <= '0;
            eng_step_reg  <= '0;
            eng_slot_reg  <= '0;
            eng_lines_reg <= '0;
            credits_reg   <= '0;
            d_valid_reg   <= 1'b0;
            w_valid_reg   <= 1'b0;
        end
        else
        begin
            eng_row_reg   <= eng_row_next;
            eng_step_reg  <= eng_step_next;
            eng_slot_reg  <= eng_slot_next;
            eng_lines_reg <= eng_lines_next;
            credits_reg   <= credits_next;
            if (adv)
            begin
                d_valid_reg <= issue;
                w_valid_reg <= d_valid_reg && d_emit_reg;
            end
        end
    end

    // tags that ride with the read data and the window
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_emit_reg <= step_emit;
            d_last_reg <= step_last;
            d_sel_reg  <= sel;
            w_last_reg <= d_last_reg;
        end
    end

    // window column chain: newest column enters at the right
    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            feed_col[i] = rdata[d_sel_reg[i]];
        end
    end

    assign win_col[W] = feed_col;

    for (genvar b = 0; b < W; b++)
    begin : g_col
        wmf_col_cell #(
            .W (W)
        ) u_col (
            .clk     (clk),
            .en      (adv && d_valid_reg),
            .col_in  (win_col[b+1]),
            .col_out (win_col[b])
        );
    end

    // first stage input: window values, live mask and rank
    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            for (int b = 0; b < W; b++)
            begin
                st_vals[0][i*W+b]  = win_col[b][i];
                st_alive[0][i*W+b] = (i >= MAX_HALF - int'(half_reg)) &&
                                     (i <= MAX_HALF + int'(half_reg)) &&
                                     (b >= W - 1 - 2 * int'(half_reg));
            end
        end
        st_k[0]         = KW'(2 * int'(half_reg) * int'(half_reg) + 2 * int'(half_reg));
        st_res[0]       = '0;
        st_ctl[0].valid = w_valid_reg;
        st_ctl[0].last  = w_last_reg;
    end

    for (genvar j = 0; j < PIX_W; j++)
    begin : g_bit
        wmf_bit_cell #(
            .N   (N),
            .KW  (KW),
            .BIT (PIX_W - 1 - j)
        ) u_bit (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .ctl_in    (st_ctl[j]),
            .vals_in   (st_vals[j]),
            .alive_in  (st_alive[j]),
            .k_in      (st_k[j]),
            .res_in    (st_res[j]),
            .ctl_out   (st_ctl[j+1]),
            .vals_out  (st_vals[j+1]),
            .alive_out (st_alive[j+1]),
            .k_out     (st_k[j+1]),
            .res_out   (st_res[j+1])
        );
    end

    // last stage is the output register
    assign out_ch.valid     = st_ctl[PIX_W].valid;
    assign out_ch.frame_end = st_ctl[PIX_W].last;
    assign out_ch.median    = st_res[PIX_W];

    // input never overruns a line slot the engine still reads
    a_lead_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(lead) <= 2 * MAX_HALF + 2)
        else $error("input line lead out of range");

    // owed outputs stay within (NL + 1) * MAX_COLS, one line more than the line stores hold
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(credits_reg) <= CRED_MAX)
        else $error("credit count out of range");

    // a complete input frame leaves the input position at the origin
    a_done_origin: assert property (@(posedge clk) disable iff (!rst_n)
        in_done_reg |-> (in_row_reg == '0 && in_col_reg == '0))
        else $error("input position not at origin while draining");

    // an output step is only taken against an owed result
    a_emit_credit: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && step_emit && !cfg_hit) |=> ($past(credits_reg) != '0))
        else $error("output step without credit");

endmodule
